// File: hdl/bytecode_stack_engine_unit_assert.svh
// assertion macros used by the port checker of the stack engine
`ifndef BYTECODE_STACK_ENGINE_UNIT_ASSERT_SVH
`define BYTECODE_STACK_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define BSE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stack engine port check failed");

// next-cycle implication, sampled on clock, off during reset
`define BSE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stack engine port check failed");

`endif

// File: hdl/bse_pkg.sv
// shared types and constants of the stack engine
`default_nettype none

package bse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int OPCODE_W    = 3;
   localparam int STATUS_W    = 2;

   // item opcodes; codes above swap leave the stack as it is and give an ok result without an entry
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH = 3'd0,
      OP_DUMP = 3'd1,
      OP_PEEK = 3'd2,
      OP_POP  = 3'd3,
      OP_SWAP = 3'd4
   } opcode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_SHORT = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // move broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_DOWN    = 3'd1,
      CELL_UP      = 3'd2,
      CELL_UP_PART = 3'd3,
      CELL_SWAP    = 3'd4
   } cell_op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SEEK = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

endpackage

`default_nettype wire

// File: hdl/bse_if.sv
// valid/ready channel interfaces of the stack engine
`default_nettype none

// command item channel
interface bse_req_if;
   import bse_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OPCODE_W-1:0]      opcode;
   logic signed [DATA_W-1:0] operand;
   modport source (output valid, output opcode, output operand, input ready);
   modport sink (input valid, input opcode, input operand, output ready);
endinterface

// result item channel
interface bse_rsp_if;
   import bse_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data_out;
   logic                     has_data;
   logic [STATUS_W-1:0]      status;
   logic                     last;
   modport source (output valid, output data_out, output has_data, output status,
                   output last, input ready);
   modport sink (input valid, input data_out, input has_data, input status,
                 input last, output ready);
endinterface

// register write channel
interface bse_csr_if;
   logic valid;
   logic ready;
   logic dump_bottom_first;
   modport source (output valid, output dump_bottom_first, input ready);
   modport sink (input valid, input dump_bottom_first, output ready);
endinterface

`default_nettype wire

// File: hdl/bytecode_stack_engine_unit.sv
// stack engine top: a chain of entry cells, a small sequencer and a result register
// push, pop, peek, swap: one item per cycle while the result is not stalled, result valid the cycle after accept
// dump top first: the first result passes the emit state and the result register, then one per cycle unless stalled
// dump bottom first: the seek state rotates the ring before the first result
// output stalls hold the sequencer; synchronous reset empties the stack and clears the
// dump-order register, entry contents are left as they are
`default_nettype none

module bytecode_stack_engine_unit #(
   parameter int DEPTH = bse_pkg::STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   bse_req_if.sink          req_chan,
   bse_rsp_if.source        rsp_chan,
   bse_csr_if.sink          csr_chan
);
   import bse_pkg::*;

   localparam int FILL_W = $clog2(DEPTH+1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);
   localparam logic [FILL_W-1:0] ONE       = FILL_W'(1);
   localparam logic [FILL_W-1:0] TWO       = FILL_W'(2);

   state_type                state_ff, state_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [FILL_W-1:0]        cnt_ff, cnt_in;
   logic                     bottom_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_has_ff, rsp_has_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_op_type              cell_op;
   logic signed [DATA_W-1:0] cell_q [DEPTH];
   logic signed [DATA_W-1:0] top_feed;
   logic                     req_fire;
   logic                     out_free;
   logic                     emit_last;

   // handshakes
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign emit_last      = ((cnt_ff + ONE) == fill_ff);

   // the top cell takes the operand on push, the ring wrap otherwise
   assign top_feed = (state_ff == ST_IDLE && cell_op == CELL_DOWN) ?
                     req_chan.operand : cell_q[DEPTH-1];

   // sequencer: next state, stack moves and result register
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      cell_op       = CELL_HOLD;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_has_in    = 1'b0;
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b1;
               case (req_chan.opcode)
                  OP_PUSH: begin
                     if (fill_ff == FULL_FILL) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cell_op = CELL_DOWN;
                        fill_in = fill_ff + ONE;
                     end
                  end
                  OP_DUMP: begin
                     // empty stack gives a single ok result without an entry
                     if (fill_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = '0;
                        if (bottom_ff && fill_ff != ONE) begin
                           state_in = ST_SEEK;
                           cnt_in   = fill_ff - ONE;
                        end else begin
                           state_in = ST_EMIT;
                        end
                     end
                  end
                  OP_PEEK: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_data_in = cell_q[0];
                        rsp_has_in  = 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        cell_op = CELL_UP;
                        fill_in = fill_ff - ONE;
                     end
                  end
                  OP_SWAP: begin
                     if (fill_ff < TWO) begin
                        rsp_status_in = STAT_SHORT;
                     end else begin
                        cell_op = CELL_SWAP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEEK: begin
            // rotate the whole ring until the bottom entry sits in the top cell
            cell_op = CELL_UP;
            cnt_in  = cnt_ff - ONE;
            if (cnt_ff == ONE) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = cell_q[0];
               rsp_has_in    = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_last_in   = emit_last;
               cnt_in        = cnt_ff + ONE;
               if (bottom_ff) begin
                  cell_op = emit_last ? CELL_HOLD : CELL_DOWN;
               end else begin
                  cell_op = CELL_UP_PART;
               end
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         bottom_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            bottom_ff <= csr_chan.dump_bottom_first;
         end
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // chain of cells, cell 0 on top, closed into a ring
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] up_val;
      logic signed [DATA_W-1:0] dn_val;
      if (i == 0) begin : g_top
         assign up_val = top_feed;
      end else begin : g_mid_up
         assign up_val = cell_q[i-1];
      end
      if (i == DEPTH-1) begin : g_end
         assign dn_val = cell_q[0];
      end else begin : g_mid_dn
         assign dn_val = cell_q[i+1];
      end
      bse_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .op       (cell_op),
         .fill     (fill_ff),
         .up_val   (up_val),
         .dn_val   (dn_val),
         .wrap_val (cell_q[0]),
         .value    (cell_q[i])
      );
   end

   // result channel
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data_out = rsp_data_ff;
   assign rsp_chan.has_data = rsp_has_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.last     = rsp_last_ff;

endmodule

`default_nettype wire

// File: hdl/bse_cell.sv
// one stack cell: holds one entry and trades it with its neighbors
`default_nettype none

module bse_cell #(
   parameter int DEPTH = bse_pkg::STACK_DEPTH,
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  bse_pkg::cell_op_type              op,
   input  logic [$clog2(DEPTH+1)-1:0]        fill,
   input  logic signed [bse_pkg::DATA_W-1:0] up_val,
   input  logic signed [bse_pkg::DATA_W-1:0] dn_val,
   input  logic signed [bse_pkg::DATA_W-1:0] wrap_val,
   output logic signed [bse_pkg::DATA_W-1:0] value
);
   import bse_pkg::*;

   localparam int FILL_W = $clog2(DEPTH+1);
   localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(INDEX + 1);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     is_bottom;

   // this cell holds the bottom entry of the stack
   assign is_bottom = (fill == LAST_POS);

   // next entry from the broadcast move
   always_comb begin
      value_in = value_ff;
      case (op)
         CELL_HOLD:    value_in = value_ff;
         CELL_DOWN:    value_in = up_val;
         CELL_UP:      value_in = dn_val;
         CELL_UP_PART: value_in = is_bottom ? wrap_val : dn_val;
         CELL_SWAP: begin
            if (INDEX == 0) begin
               value_in = dn_val;
            end else if (INDEX == 1) begin
               value_in = up_val;
            end
         end
         default:      value_in = value_ff;
      endcase
   end

   // entry register
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// File: hdl/bse_checker.sv
// port checker of the stack engine and its bind to the top level
`default_nettype none
`include "bytecode_stack_engine_unit_assert.svh"

module bse_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [bse_pkg::DATA_W-1:0] rsp_data_out,
   input logic                              rsp_has_data,
   input logic [bse_pkg::STATUS_W-1:0]      rsp_status,
   input logic                              rsp_last
);
   import bse_pkg::*;

   // a stalled result keeps its entry
   `BSE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out))

   // an entry only comes with ok status
   `BSE_ASSERT_IMP(a_data_ok, rsp_valid && rsp_has_data, rsp_status == STAT_OK)

   // results without an entry carry zero
   `BSE_ASSERT_IMP(a_no_data_zero, rsp_valid && !rsp_has_data, rsp_data_out == '0)

   // no new item while a dump is still running
   `BSE_ASSERT_IMP(a_dump_busy, rsp_valid && !rsp_last, !req_ready)

endmodule

bind bytecode_stack_engine_unit bse_checker u_bse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_data_out (rsp_chan.data_out),
   .rsp_has_data (rsp_chan.has_data),
   .rsp_status   (rsp_chan.status),
   .rsp_last     (rsp_chan.last)
);

`default_nettype wire
